[hw/rtl/dbm_pkg.sv]
// Shared types and constants for the digest bucket modulo block.
// No dependencies; imported by the cell, the top level and the checker.
package dbm_pkg;

  localparam int unsigned DIGEST_W = 128;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned MOD_W    = 32;
  localparam int unsigned NCELL    = DIGEST_W;

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1);

  // One item as it moves down the cell row.
  typedef struct packed {
    logic                vld;
    logic [MOD_W-1:0]    rem;
    logic [DIGEST_W-1:0] bits;  // digest bits not yet folded, msb first
  } stage_t;

endpackage

[hw/rtl/dbm_cell.sv]
// One cell of the restoring reduction row: folds one digest bit into
// the running remainder. Depends on dbm_pkg.
module dbm_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [dbm_pkg::MOD_W-1:0]  modulus,
  input  dbm_pkg::stage_t            stage_in,
  output dbm_pkg::stage_t            stage_out
);
  import dbm_pkg::*;

  logic                vld_r;
  logic [MOD_W-1:0]    rem_r;
  logic [DIGEST_W-1:0] bits_r;

  logic [MOD_W:0]      shifted;
  logic [MOD_W:0]      diff;
  logic [MOD_W-1:0]    rem_nxt;
  logic [DIGEST_W-1:0] bits_nxt;

  // rem < n, so 2*rem + bit < 2n and one conditional subtract suffices
  always_comb begin
    shifted  = {stage_in.rem, stage_in.bits[DIGEST_W-1]};
    diff     = shifted - {1'b0, modulus};
    bits_nxt = {stage_in.bits[DIGEST_W-2:0], 1'b0};
    if (modulus == '0) begin
      rem_nxt = '0;
    end else if (shifted >= {1'b0, modulus}) begin
      rem_nxt = diff[MOD_W-1:0];
    end else begin
      rem_nxt = shifted[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= stage_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      bits_r <= bits_nxt;
    end
  end

  assign stage_out.vld  = vld_r;
  assign stage_out.rem  = rem_r;
  assign stage_out.bits = bits_r;

endmodule

[hw/rtl/digest_bucket_modulo.sv]
// Top level: 128-bit digest modulo a configured 32-bit modulus.
// Depends on dbm_pkg and dbm_cell.
//
//  channel   dir  handshake               payload
//  in_       in   in_tvalid/in_tready     in_tdata[127:0]  digest_hi, digest_lo
//  out_      out  out_tvalid/out_tready   out_tdata[31:0]  remainder
//  cfg_      in   cfg_wr_en               cfg_wr_data[31:0] modulus
//
// One item per cycle unless the output stalls. The path is a row of 128 cells,
// one digest bit each, then the output register.
// rst_n clears all valid flags and sets the modulus to 1.
// The whole row halts, and in_tready drops, only when its last cell and the
// output register both hold items and out_tready is low.
module digest_bucket_modulo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,    // [63:0] digest_hi, [127:64] digest_lo
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,   // [31:0] remainder
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data  // modulus
);
  import dbm_pkg::*;

  logic [MOD_W-1:0] modulus_r;
  logic             out_valid_r;
  logic [MOD_W-1:0] out_data_r;
  logic             out_load;
  logic             adv;

  stage_t chain [0:NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  assign out_load  = !out_valid_r || out_tready;
  assign adv       = !chain[NCELL].vld || out_load;
  assign in_tready = adv;

  assign chain[0].vld  = in_tvalid && adv;
  assign chain[0].rem  = '0;
  assign chain[0].bits = {in_tdata[HALF_W-1:0], in_tdata[DIGEST_W-1:HALF_W]};

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    dbm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .modulus   (modulus_r),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= chain[NCELL].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= chain[NCELL].rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/dbm_checker.sv]
// Port-level checks for digest_bucket_modulo, bound to the top level.
// Depends on dbm_pkg for the modulus reset value.
module dbm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata,
  input logic         cfg_wr_en,
  input logic [31:0]  cfg_wr_data
);
  import dbm_pkg::*;

  logic [MOD_W-1:0] mod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_RESET;
    end else if (cfg_wr_en) begin
      mod_r <= cfg_wr_data;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mod_r != '0 |-> out_tdata < mod_r)
    else $error("remainder not below modulus");

  a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mod_r == '0 |-> out_tdata == '0)
    else $error("nonzero remainder with zero modulus");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind digest_bucket_modulo dbm_checker u_dbm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);
